@@ hdl/ipd_pkg.sv @@
package ipd_pkg;

    localparam int unsigned IMAGE_ROWS = 32;
    localparam int unsigned IMAGE_COLS = 32;

    localparam int unsigned LEVEL_W   = 4;
    localparam int unsigned OUT_ROW_W = 5;
    localparam int unsigned OUT_COL_W = 5;
    localparam int unsigned GLYPH_W   = 7;

    localparam int unsigned ROW_CNT_W = $clog2(IMAGE_ROWS);
    localparam int unsigned COL_CNT_W = $clog2(IMAGE_COLS);

    localparam int unsigned LAST_ROW = IMAGE_ROWS - 1;
    localparam int unsigned LAST_COL = IMAGE_COLS - 1;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [LEVEL_W-1:0] THRESH_RESET    = 4'd2;
    localparam logic [LEVEL_W-1:0] MAX_GLYPH_LEVEL = 4'd9;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // One correction job: a pixel of the row above the input, with its neighbours
    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [LEVEL_W-1:0]   center;
        logic [LEVEL_W-1:0]   right;
        logic [LEVEL_W-1:0]   below;
        logic                 has_below;
        logic                 has_right;
        logic                 has_top;
        logic                 has_left;
        logic                 last;
    } job_t;

    typedef struct packed {
        logic flushing;
    } front_stat_t;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] lvl);
        logic [GLYPH_W-1:0] g;
        case (lvl)
            4'd0:    g = 7'h20;  // ' '
            4'd1:    g = 7'h2e;  // '.'
            4'd2:    g = 7'h27;  // '\''
            4'd3:    g = 7'h3a;  // ':'
            4'd4:    g = 7'h7e;  // '~'
            4'd5:    g = 7'h2a;  // '*'
            4'd6:    g = 7'h3d;  // '='
            4'd7:    g = 7'h7d;  // '}'
            4'd8:    g = 7'h26;  // '&'
            4'd9:    g = 7'h23;  // '#'
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

@@ hdl/ipd_front.sv @@
module ipd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pix_valid,
    output logic                        pix_ready,
    input  logic [ipd_pkg::LEVEL_W-1:0] pix_level,
    output logic                        job_valid,
    input  logic                        job_ready,
    output ipd_pkg::job_t               job,
    output ipd_pkg::front_stat_t        stat
);

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t                             state_reg, state_next;
    logic [ipd_pkg::ROW_CNT_W-1:0]      row_reg, row_next;
    logic [ipd_pkg::COL_CNT_W-1:0]      col_reg, col_next;
    logic [ipd_pkg::COL_CNT_W-1:0]      fcol_reg, fcol_next;
    // raw previous row as a delay line: tap LAST_COL is the pixel straight above
    logic [ipd_pkg::LEVEL_W-1:0]        raw_reg [ipd_pkg::IMAGE_COLS];
    logic                               accept;
    logic                               shift_en;
    logic                               last_col;
    logic                               last_fcol;

    assign pix_ready = (state_reg == ST_RUN) && job_ready;
    assign accept    = pix_valid && pix_ready;
    assign last_col  = (col_reg == ipd_pkg::COL_CNT_W'(ipd_pkg::LAST_COL));
    assign last_fcol = (fcol_reg == ipd_pkg::COL_CNT_W'(ipd_pkg::LAST_COL));
    assign shift_en  = accept || ((state_reg == ST_FLUSH) && job_ready);
    assign stat.flushing = (state_reg == ST_FLUSH);

    always_comb
    begin
        job.center = raw_reg[ipd_pkg::IMAGE_COLS-1];
        job.right  = raw_reg[ipd_pkg::IMAGE_COLS-2];
        if (state_reg == ST_FLUSH)
        begin
            job_valid     = 1'b1;
            job.row       = ipd_pkg::OUT_ROW_W'(ipd_pkg::LAST_ROW);
            job.col       = ipd_pkg::OUT_COL_W'(fcol_reg);
            job.below     = '0;
            job.has_below = 1'b0;
            job.has_right = !last_fcol;
            job.has_top   = 1'b1;
            job.has_left  = (fcol_reg != '0);
            job.last      = last_fcol;
        end
        else
        begin
            job_valid     = accept && (row_reg != '0);
            job.row       = ipd_pkg::OUT_ROW_W'(row_reg - ipd_pkg::ROW_CNT_W'(1));
            job.col       = ipd_pkg::OUT_COL_W'(col_reg);
            job.below     = pix_level;
            job.has_below = 1'b1;
            job.has_right = !last_col;
            job.has_top   = (row_reg > ipd_pkg::ROW_CNT_W'(1));
            job.has_left  = (col_reg != '0);
            job.last      = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        fcol_next  = fcol_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (last_col)
                    begin
                        col_next = '0;
                        if (row_reg == ipd_pkg::ROW_CNT_W'(ipd_pkg::LAST_ROW))
                        begin
                            row_next   = '0;
                            fcol_next  = '0;
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            row_next = row_reg + ipd_pkg::ROW_CNT_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + ipd_pkg::COL_CNT_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (job_ready)
                begin
                    fcol_next = fcol_reg + ipd_pkg::COL_CNT_W'(1);
                    if (last_fcol)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            row_reg   <= '0;
            col_reg   <= '0;
            fcol_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            fcol_reg  <= fcol_next;
        end
    end

    // during the flush the line walks the last row past the taps
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            raw_reg[0] <= accept ? pix_level : '0;
            for (int k = 1; k < ipd_pkg::IMAGE_COLS; k++)
            begin
                raw_reg[k] <= raw_reg[k-1];
            end
        end
    end

endmodule

@@ hdl/ipd_job_fifo.sv @@
module ipd_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ipd_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ipd_pkg::job_t pop_job
);

    ipd_pkg::job_t                  mem [ipd_pkg::FIFO_DEPTH];
    logic [ipd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ipd_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ipd_pkg::FIFO_PTR_W:0]   count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != (ipd_pkg::FIFO_PTR_W+1)'(ipd_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + ipd_pkg::FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + ipd_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (ipd_pkg::FIFO_PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (ipd_pkg::FIFO_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ hdl/ipd_back.sv @@
module ipd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ipd_pkg::LEVEL_W-1:0] threshold,
    input  logic                        job_valid,
    output logic                        job_ready,
    input  ipd_pkg::job_t               job,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [ipd_pkg::OUT_ROW_W-1:0] res_row,
    output logic [ipd_pkg::OUT_COL_W-1:0] res_col,
    output logic [ipd_pkg::LEVEL_W-1:0]   res_level,
    output logic [ipd_pkg::GLYPH_W-1:0]   res_glyph,
    output logic                          res_error,
    output logic                          res_last
);

    logic                          out_valid_reg, out_valid_next;
    logic [ipd_pkg::OUT_ROW_W-1:0] row_reg;
    logic [ipd_pkg::OUT_COL_W-1:0] col_reg;
    logic [ipd_pkg::LEVEL_W-1:0]   level_reg;
    logic [ipd_pkg::GLYPH_W-1:0]   glyph_reg;
    logic                          error_reg;
    logic                          last_reg;
    // corrected row above as a delay line, tap LAST_COL is the top neighbour
    logic [ipd_pkg::LEVEL_W-1:0]   above_reg [ipd_pkg::IMAGE_COLS];
    logic [ipd_pkg::LEVEL_W-1:0]   left_reg;

    logic                          take;
    logic [ipd_pkg::LEVEL_W-1:0]   top;
    logic                          keep;
    logic [5:0]                    sum;
    logic [2:0]                    cnt;
    logic [13:0]                   prod3;
    logic [4:0]                    q3;
    logic [5:0]                    r3;
    logic [5:0]                    quo;
    logic                          inc;
    logic [5:0]                    mean;
    logic [ipd_pkg::LEVEL_W-1:0]   lvl;

    function automatic logic close_to(input logic [ipd_pkg::LEVEL_W-1:0] a,
                                      input logic [ipd_pkg::LEVEL_W-1:0] b,
                                      input logic [ipd_pkg::LEVEL_W-1:0] th);
        logic [ipd_pkg::LEVEL_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d < th;
    endfunction

    assign job_ready = !out_valid_reg || res_ready;
    assign take      = job_valid && job_ready;
    assign top       = above_reg[ipd_pkg::IMAGE_COLS-1];

    always_comb
    begin
        keep = (job.has_below && close_to(job.center, job.below, threshold))
            || (job.has_right && close_to(job.center, job.right, threshold))
            || (job.has_top   && close_to(job.center, top, threshold))
            || (job.has_left  && close_to(job.center, left_reg, threshold));

        sum = (job.has_below ? 6'(job.below) : 6'd0)
            + (job.has_right ? 6'(job.right) : 6'd0)
            + (job.has_top   ? 6'(top)       : 6'd0)
            + (job.has_left  ? 6'(left_reg)  : 6'd0);
        cnt = 3'(job.has_below) + 3'(job.has_right) + 3'(job.has_top) + 3'(job.has_left);

        // sum / 3 by reciprocal, exact for sum up to 60
        prod3 = 14'(sum) * 14'd171;
        q3    = prod3[13:9];
        r3    = sum - (6'(q3) + 6'(q3) + 6'(q3));

        case (cnt)
            3'd1:
            begin
                quo = sum;
                inc = 1'b0;
            end
            3'd2:
            begin
                quo = sum >> 1;
                inc = sum[0] && quo[0];
            end
            3'd3:
            begin
                quo = 6'(q3);
                inc = (r3[1:0] == 2'd2);
            end
            3'd4:
            begin
                quo = sum >> 2;
                inc = (sum[1:0] == 2'd3) || ((sum[1:0] == 2'd2) && quo[0]);
            end
            default:
            begin
                quo = 6'(job.center);
                inc = 1'b0;
            end
        endcase
        mean = quo + 6'(inc);
        lvl  = keep ? job.center : mean[ipd_pkg::LEVEL_W-1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                left_reg <= lvl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            row_reg      <= job.row;
            col_reg      <= job.col;
            level_reg    <= lvl;
            glyph_reg    <= ipd_pkg::glyph_of(lvl);
            error_reg    <= (lvl > ipd_pkg::MAX_GLYPH_LEVEL);
            last_reg     <= job.last;
            above_reg[0] <= lvl;
            for (int k = 1; k < ipd_pkg::IMAGE_COLS; k++)
            begin
                above_reg[k] <= above_reg[k-1];
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res_row   = row_reg;
    assign res_col   = col_reg;
    assign res_level = level_reg;
    assign res_glyph = glyph_reg;
    assign res_error = error_reg;
    assign res_last  = last_reg;

endmodule

@@ hdl/isolated_pixel_deglitch.sv @@
// Isolated pixel deglitch: four-neighbour impulse noise removal, in place.
// Slave stream s_*: one pixel level per transaction, raster order, rows of
// IMAGE_COLS, frames of IMAGE_ROWS rows. Master stream m_*: corrected pixels.
// The result for pixel (i,j) leaves once pixel (i+1,j) is taken, via the job
// queue and output register. The first row gives no results. Throughput is one
// pixel per cycle while m_tready is high. The last pixel of a frame starts a
// flush that walks the final row through the correction unit, one column per
// cycle while the queue has room: IMAGE_COLS results, the last one with
// m_tlast, during which s_tready stays low; the next frame starts right after.
// Config channel cfg_*: writes glitch_threshold (reset value 2). Write it only
// while the block is idle.
// A four-entry job queue sits between the input side and the correction unit;
// when m_tready is low the output register holds, the queue fills and then
// s_tready drops.
// Reset clears the counters, queue and output valid; row stores hold no reset
// value and are always written before they are read within a frame.
module isolated_pixel_deglitch (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ipd_pkg::S_TDATA_W-1:0] s_tdata,   // [3:0] pixel_level
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [4:0] out_row, [9:5] out_col, [13:10] out_level, [20:14] glyph
    output logic [ipd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,   // [0] level_error
    output logic                          m_tlast,   // frame_last
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ipd_pkg::LEVEL_W-1:0]   cfg_data   // glitch_threshold
);

    logic [ipd_pkg::LEVEL_W-1:0]   thresh_reg;
    logic                          fq_valid;
    logic                          fq_ready;
    ipd_pkg::job_t                 fq_job;
    logic                          qb_valid;
    logic                          qb_ready;
    ipd_pkg::job_t                 qb_job;
    ipd_pkg::front_stat_t          front_stat;
    logic [ipd_pkg::OUT_ROW_W-1:0] res_row;
    logic [ipd_pkg::OUT_COL_W-1:0] res_col;
    logic [ipd_pkg::LEVEL_W-1:0]   res_level;
    logic [ipd_pkg::GLYPH_W-1:0]   res_glyph;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= ipd_pkg::THRESH_RESET;
        end
        else if (cfg_valid)
        begin
            thresh_reg <= cfg_data;
        end
    end

    ipd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (s_tvalid),
        .pix_ready (s_tready),
        .pix_level (s_tdata[ipd_pkg::LEVEL_W-1:0]),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job),
        .stat      (front_stat)
    );

    ipd_job_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    ipd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thresh_reg),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_row   (res_row),
        .res_col   (res_col),
        .res_level (res_level),
        .res_glyph (res_glyph),
        .res_error (m_tuser),
        .res_last  (m_tlast)
    );

    assign m_tdata = {3'b000, res_glyph, res_level, res_col, res_row};

`ifndef SYNTHESIS
    a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.flushing |-> !s_tready)
        else $error("input taken during row flush");

    a_error_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (res_level > ipd_pkg::MAX_GLYPH_LEVEL)))
        else $error("level_error disagrees with level");

    a_error_no_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (res_glyph == '0))
        else $error("glyph present on out-of-range level");

    a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
            (res_col == ipd_pkg::OUT_COL_W'(ipd_pkg::LAST_COL))
            && (res_row == ipd_pkg::OUT_ROW_W'(ipd_pkg::LAST_ROW)))
        else $error("frame end flagged away from last pixel");
`endif

endmodule
